/* sv/kls_pkg.sv */
// kls_pkg: shared constants and types for the key list sorter
// used by kls_cell and key_list_sorter; no dependencies
package kls_pkg;

  // default sizes of the sorting chain
  localparam int unsigned DEPTH_DEF     = 64;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  // width of the key field on both stream ports
  localparam int unsigned DATA_W = 32;

  // status one cell shows its neighbors
  typedef struct packed {
    logic vld;  // cell holds a key
    logic gt;   // held key is greater than the key being inserted
  } cell_stat_t;

endpackage

/* sv/kls_cell.sv */
// kls_cell: one cell of the insertion chain, holds a single key
// depends on kls_pkg (cell_stat_t)
module kls_cell #(
  parameter int unsigned KEY_WIDTH = kls_pkg::KEY_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   ins_i,          // insert new_key_i into the chain
  input  logic                   shift_i,        // pop: take the right neighbor's key
  input  logic [KEY_WIDTH-1:0]   new_key_i,
  input  logic [KEY_WIDTH-1:0]   left_key_i,
  input  kls_pkg::cell_stat_t    left_stat_i,
  input  logic [KEY_WIDTH-1:0]   right_key_i,
  input  kls_pkg::cell_stat_t    right_stat_i,
  output logic [KEY_WIDTH-1:0]   key_o,
  output kls_pkg::cell_stat_t    stat_o
);

  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic                 vld_q, vld_d;
  logic                 gt;

  // compare held key with the broadcast key
  assign gt = vld_q && (key_q > new_key_i);

  // next content: keep, take from left or the new key on insert, take from right on pop
  always_comb begin
    key_d = key_q;
    vld_d = vld_q;
    if (shift_i) begin
      key_d = right_key_i;
      vld_d = right_stat_i.vld;
    end else if (ins_i) begin
      if (gt) begin
        key_d = left_stat_i.gt ? left_key_i : new_key_i;
      end else if (!vld_q) begin
        if (left_stat_i.gt) begin
          key_d = left_key_i;
          vld_d = 1'b1;
        end else if (left_stat_i.vld) begin
          key_d = new_key_i;
          vld_d = 1'b1;
        end
      end
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // key payload
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o      = key_q;
  assign stat_o.vld = vld_q;
  assign stat_o.gt  = gt;

endmodule

/* sv/key_list_sorter.sv */
// key_list_sorter: ascending sort of a key list in a chain of insertion cells
// depends on kls_pkg and kls_cell
//
// Usage:
//   Keys enter on the s_axis channel, one per transaction, the final key of a
//   list flagged by s_axis_tlast. Each key is inserted into a chain of DEPTH
//   cells that stays sorted; keys may arrive back to back. A key that arrives
//   while all cells are full is dropped and remembered.
//   After the transaction with tlast the chain unloads on m_axis: the smallest
//   key leaves from cell 0 and every cell takes its right neighbor's key, one
//   key per cycle while m_axis_tready is high. The first sorted key is shown
//   the cycle after the final key is taken. m_axis_tlast marks the final key,
//   m_axis_tuser flags a list that lost keys to a full chain.
//   s_axis_tready stays low while the single shift chain unloads. A stalled
//   receiver simply holds the chain. Reset empties all cells and clears the
//   drop flag; the block is ready as soon as reset is released.
module key_list_sorter #(
  parameter int unsigned DEPTH     = kls_pkg::DEPTH_DEF,
  parameter int unsigned KEY_WIDTH = kls_pkg::KEY_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [kls_pkg::DATA_W-1:0] s_axis_tdata,   // [31:0] key
  input  logic                       s_axis_tlast,   // last_in
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [kls_pkg::DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_key
  output logic                       m_axis_tlast,   // last_out
  output logic                       m_axis_tuser    // [0] overflow
);

  logic [KEY_WIDTH-1:0]  cell_key  [DEPTH];
  kls_pkg::cell_stat_t   cell_stat [DEPTH];
  logic [DEPTH-1:0]      vld_vec;
  logic [KEY_WIDTH-1:0]  new_key;
  logic                  in_acc, out_acc, full, ins;
  logic                  drain_q, drain_d;
  logic                  dropped_q, dropped_d;

  // handshakes and chain control
  assign new_key       = KEY_WIDTH'(s_axis_tdata);
  assign s_axis_tready = !drain_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign full          = cell_stat[DEPTH-1].vld;
  assign ins           = in_acc && !full;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  // chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    kls_pkg::cell_stat_t  lstat, rstat;
    logic [KEY_WIDTH-1:0] lkey, rkey;

    if (i == 0) begin : g_left_edge
      assign lstat = '{vld: 1'b1, gt: 1'b0};
      assign lkey  = '0;
    end else begin : g_left
      assign lstat = cell_stat[i-1];
      assign lkey  = cell_key[i-1];
    end

    if (i == DEPTH - 1) begin : g_right_edge
      assign rstat = '{vld: 1'b0, gt: 1'b0};
      assign rkey  = '0;
    end else begin : g_right
      assign rstat = cell_stat[i+1];
      assign rkey  = cell_key[i+1];
    end

    kls_cell #(
      .KEY_WIDTH(KEY_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ins_i       (ins),
      .shift_i     (out_acc),
      .new_key_i   (new_key),
      .left_key_i  (lkey),
      .left_stat_i (lstat),
      .right_key_i (rkey),
      .right_stat_i(rstat),
      .key_o       (cell_key[i]),
      .stat_o      (cell_stat[i])
    );

    assign vld_vec[i] = cell_stat[i].vld;
  end

  // unload and drop flag control
  always_comb begin
    drain_d   = drain_q;
    dropped_d = dropped_q;
    if (in_acc && full) begin
      dropped_d = 1'b1;
    end
    if (in_acc && s_axis_tlast) begin
      drain_d = 1'b1;
    end
    if (out_acc && m_axis_tlast) begin
      drain_d   = 1'b0;
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q   <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      drain_q   <= drain_d;
      dropped_q <= dropped_d;
    end
  end

  // output key straight from the head cell, tlast from the cell behind it, tvalid and tuser from the flags
  assign m_axis_tvalid = drain_q;
  assign m_axis_tdata  = kls_pkg::DATA_W'(cell_key[0]);
  assign m_axis_tlast  = !cell_stat[1].vld;
  assign m_axis_tuser  = dropped_q;

  // occupied cells always form a prefix of the chain
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, vld_vec} + (DEPTH + 1)'(1)))
    else $error("cell valid bits are not a contiguous prefix");

  // unloading never shows an empty head cell
  a_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cell_stat[0].vld)
    else $error("unloading with an empty chain");

  // the final sorted key leaves the chain empty and the drop flag clear
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast) |=> (vld_vec == '0) && !dropped_q)
    else $error("chain not empty after final sorted key");

  // a key taken while full marks the list as overflowed
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && full) |=> dropped_q)
    else $error("dropped key not flagged");

endmodule

/* tb/tb.sv */
// tb: self-checking testbench for key_list_sorter, streams key lists and checks sorted output
// depends on kls_pkg and key_list_sorter
module tb;

  localparam int unsigned LIST_DEPTH  = kls_pkg::DEPTH_DEF;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RANDOM_KEYS = 130;
  localparam int unsigned HOLD_CYCLES = 300;

  // one sorted key as the output port shows it
  typedef struct packed {
    logic [kls_pkg::DATA_W-1:0] key;
    logic                       last;
    logic                       overflow;
  } sorted_rec_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [kls_pkg::DATA_W-1:0] s_axis_tdata;   // [31:0] key
  logic                       s_axis_tlast;   // last_in
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [kls_pkg::DATA_W-1:0] m_axis_tdata;   // [31:0] sorted_key
  logic                       m_axis_tlast;   // last_out
  logic                       m_axis_tuser;   // [0] overflow

  // predictor state: keys of the open list kept in ascending order
  logic [kls_pkg::DATA_W-1:0] loaded_keys[$];
  bit                         keys_dropped;
  sorted_rec_t                pending_sorted[$];

  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned sink_hold;
  bit          src_jitter;
  bit          sink_jitter;

  key_list_sorter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // insert an accepted key (flag a drop if full); on the final key emit the whole list in order
  task automatic predict_sorted_run(input logic [kls_pkg::DATA_W-1:0] key, input logic last);
    int pos;
    int n;
    if (loaded_keys.size() < LIST_DEPTH) begin
      pos = loaded_keys.size();
      while (pos > 0 && loaded_keys[pos-1] > key) pos--;
      loaded_keys.insert(pos, key);
    end else begin
      keys_dropped = 1'b1;
    end
    if (last) begin
      n = loaded_keys.size();
      for (int k = 0; k < n; k++)
        pending_sorted.push_back('{key: loaded_keys[k], last: (k == n - 1),
                                   overflow: keys_dropped});
      loaded_keys.delete();
      keys_dropped = 1'b0;
    end
  endtask

  // one key transaction on the input side
  task automatic send_key(input logic [kls_pkg::DATA_W-1:0] key, input logic last);
    int gap;
    gap = src_jitter ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = key;
    s_axis_tlast  = last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_sorted_run(key, last);
  endtask

  task automatic idle_source;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;
  endtask

  task automatic wait_drained;
    idle_source();
    while (pending_sorted.size() != 0) @(posedge clk_i);
  endtask

  // mostly full-range keys, some extremes and a narrow range for duplicates
  function automatic logic [kls_pkg::DATA_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return kls_pkg::DATA_W'($urandom_range(0, 15));
      default: return kls_pkg::DATA_W'($urandom);
    endcase
  endfunction

  task automatic send_random_list(input int n);
    for (int i = 0; i < n; i++) send_key(pick_key(), i == n - 1);
  endtask

  // extreme key values, duplicates and a one-key list
  task automatic test_extreme_keys;
    logic [kls_pkg::DATA_W-1:0] keys[8];
    keys = '{'0, '1, '0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555};
    send_key('1, 1'b1);
    foreach (keys[i]) send_key(keys[i], i == 7);
  endtask

  // reversed and already ordered lists
  task automatic test_ordering;
    for (int i = 0; i < 6; i++) send_key(32'hF000_0000 - kls_pkg::DATA_W'(i * 7), i == 5);
    for (int i = 0; i < 5; i++) send_key(kls_pkg::DATA_W'(i * 3), i == 4);
  endtask

  // store exactly full, final key dropped, several keys dropped
  task automatic test_store_full;
    send_random_list(LIST_DEPTH);
    send_random_list(LIST_DEPTH + 1);
    send_random_list(LIST_DEPTH + 6);
  endtask

  // receiver holds off while the next list is offered, so the input stalls
  task automatic test_output_backpressure;
    sink_hold = HOLD_CYCLES;
    send_random_list(40);
    send_random_list(10);
  endtask

  // sender waits for every sorted key before the next list
  task automatic test_drain_pause;
    send_random_list(12);
    wait_drained();
    send_random_list(3);
  endtask

  task automatic test_random_lists;
    int sent;
    int n;
    sent = 0;
    while (sent < RANDOM_KEYS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: n = $urandom_range(1, 8);
        7, 8:                n = $urandom_range(9, LIST_DEPTH);
        default:             n = $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 6);
      endcase
      src_jitter  = $urandom_range(0, 3) != 0;
      sink_jitter = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 5) == 0) wait_drained();
      send_random_list(n);
      sent += n;
    end
    src_jitter  = 1'b1;
    sink_jitter = 1'b1;
  endtask

  // receiver: random stall per result, or a long hold on request
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold != 0) begin
        m_axis_tready = 1'b0;
        repeat (sink_hold) @(negedge clk_i);
        sink_hold = 0;
      end else if (sink_jitter) begin
        stall = $urandom_range(0, 3);
        if (stall != 0) begin
          m_axis_tready = 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid && sink_hold == 0) @(posedge clk_i);
    end
  end

  // compare each output transaction with the oldest predicted key
  always @(posedge clk_i) begin
    sorted_rec_t exp_rec;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_sorted.size() == 0) begin
        report_mismatch($sformatf("unexpected key %h", m_axis_tdata));
      end else begin
        exp_rec = pending_sorted.pop_front();
        if (m_axis_tdata !== exp_rec.key)
          report_mismatch($sformatf("sorted_key %h, want %h", m_axis_tdata, exp_rec.key));
        if (m_axis_tlast !== exp_rec.last)
          report_mismatch($sformatf("last_out %b, want %b (key %h)",
                                    m_axis_tlast, exp_rec.last, exp_rec.key));
        if (m_axis_tuser !== exp_rec.overflow)
          report_mismatch($sformatf("overflow %b, want %b (key %h)",
                                    m_axis_tuser, exp_rec.overflow, exp_rec.key));
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    keys_dropped   = 1'b0;
    mismatch_count = 0;
    idle_cycles    = 0;
    sink_hold      = 0;
    src_jitter     = 1'b1;
    sink_jitter    = 1'b1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_extreme_keys();
    test_ordering();
    test_store_full();
    test_output_backpressure();
    test_drain_pause();
    test_random_lists();

    wait_drained();
    repeat (2 * LIST_DEPTH) @(posedge clk_i);
    if (pending_sorted.size() != 0 || loaded_keys.size() != 0)
      report_mismatch("predicted keys left over at end");
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
